// ===== design/cpp_pkg.sv =====
// ---------------------------------------------------------------------------
// cpp_pkg: shared types and constants of the camera point projector
// Port words, register indexes, divider stage types and the helper
// functions used by the projector and its depth divider.
// ---------------------------------------------------------------------------
package cpp_pkg;

   localparam int CSR_DATA_W = 36;
   localparam int DIV_STEPS  = 22;
   localparam int DEN_W      = 46;

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_PERSP = 2'd2;

   localparam longint K_Q8     = 4194304;
   localparam longint KNEE_Q8  = 262144;
   localparam longint NUM_BIAS = (longint'(1) << 44) - 1;
   localparam longint OUT_MAX  = 8388607;
   localparam longint OUT_MIN  = -8388608;

   typedef enum logic [2:0] {
      CSR_CAMERA_X,
      CSR_CAMERA_Y,
      CSR_CAMERA_Z,
      CSR_YAW_PAIR,
      CSR_PITCH_PAIR,
      CSR_SCREEN_CENTRE,
      CSR_VIEW_SCALE,
      CSR_PROJECTION_MODE
   } csr_index_type;

   typedef struct packed {
      logic signed [31:0] world_x;
      logic signed [31:0] world_y;
      logic signed [31:0] world_z;
   } req_word_type;

   typedef struct packed {
      logic signed [23:0] screen_x;
      logic signed [23:0] screen_y;
      logic               point_valid;
   } rsp_word_type;

   typedef struct packed {
      logic [DEN_W-1:0]     den;
      logic [DIV_STEPS-1:0] num_lo;
      logic [DEN_W-1:0]     rem;
      logic [DIV_STEPS-1:0] quo;
   } cpp_div_type;

   typedef struct packed {
      logic signed [47:0] hx;
      logic signed [50:0] hy;
      logic signed [45:0] d;
      logic               knee;
   } cpp_side_type;

   // four partial products of a 51 x 46 magnitude product
   function automatic logic [96:0] split_sum(input logic [48:0] ll, input logic [48:0] lh,
                                             input logic [47:0] hl, input logic [47:0] hh);
      return 97'(ll) + (97'(lh) << 23) + (97'(hl) << 26) + (97'(hh) << 49);
   endfunction

   // floor of the signed product over 2^22, capped where the output saturates anyway
   function automatic logic signed [50:0] shrink_offset(input logic [96:0] p, input logic neg);
      logic [30:0] mag;
      if (|p[96:52]) begin
         mag = 31'd1 << 30;
      end else begin
         mag = {1'b0, p[51:22]} + 31'(neg && (|p[21:0]));
      end
      return neg ? -51'(mag) : 51'(mag);
   endfunction

   function automatic logic signed [23:0] sat_out(input logic signed [52:0] v);
      logic signed [48:0] q;
      q = v[52:4];
      if (q > 49'(OUT_MAX)) begin
         return 24'(OUT_MAX);
      end else if (q < 49'(OUT_MIN)) begin
         return 24'(OUT_MIN);
      end
      return q[23:0];
   endfunction

endpackage

// ===== design/cpp_divider.sv =====
// ---------------------------------------------------------------------------
// cpp_divider: pipelined restoring divider for depth compression
// One quotient bit per stage, most significant first; the side data of
// each word travels alongside and all stages move on advance.
// ---------------------------------------------------------------------------
module cpp_divider (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  cpp_pkg::cpp_div_type           in_div,
   input  cpp_pkg::cpp_side_type          in_side,
   output logic                           out_valid,
   output logic [cpp_pkg::DIV_STEPS-1:0]  out_quo,
   output cpp_pkg::cpp_side_type          out_side
);
   import cpp_pkg::*;

   logic         valid_ff [DIV_STEPS];
   cpp_div_type  div_ff   [DIV_STEPS];
   cpp_side_type side_ff  [DIV_STEPS];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic           src_valid;
      cpp_div_type    src_div;
      cpp_side_type   src_side;
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           take;
      cpp_div_type    div_in;

      if (k == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_div   = in_div;
         assign src_side  = in_side;
      end else begin : g_body
         assign src_valid = valid_ff[k-1];
         assign src_div   = div_ff[k-1];
         assign src_side  = side_ff[k-1];
      end

      assign trial = {src_div.rem, src_div.num_lo[DIV_STEPS-1]};
      assign diff  = trial - {1'b0, src_div.den};
      assign take  = trial >= {1'b0, src_div.den};

      always_comb begin
         div_in.den    = src_div.den;
         div_in.num_lo = {src_div.num_lo[DIV_STEPS-2:0], 1'b0};
         div_in.rem    = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         div_in.quo    = {src_div.quo[DIV_STEPS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            div_ff[k]  <= div_in;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quo   = div_ff[DIV_STEPS-1].quo;
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

// ===== design/camera_point_projection.sv =====
// ---------------------------------------------------------------------------
// camera_point_projection: world point to screen position projector
// Offsets a world point by the camera, rotates it by yaw and pitch,
// scales it, optionally compresses depth and places it on screen.
// ---------------------------------------------------------------------------
// Takes one point per clock while req_ready is high and returns one word
// per point, in order. The 22-stage depth divider sits in the middle of
// the pipeline; the rotation, scaling and depth multiplies take ten stages
// ahead of and behind it, and the output register adds the last one. A
// skid register after the output register lets one more word leave the
// pipeline while an output word waits; after that req_ready stays low
// until the waiting word is taken. Registers must be written through the
// csr port only while no points are in flight; the block itself does not enforce this.
module camera_point_projection (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cpp_pkg::req_word_type               req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cpp_pkg::rsp_word_type               rsp_word,
   input  logic                                csr_we,
   input  cpp_pkg::csr_index_type              csr_index,
   input  logic [cpp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import cpp_pkg::*;

   logic signed [31:0] camera_x_ff, camera_y_ff, camera_z_ff;
   logic [35:0]        yaw_pair_ff, pitch_pair_ff;
   logic [23:0]        screen_centre_ff;
   logic [15:0]        view_scale_ff;
   logic [1:0]         projection_mode_ff;

   logic signed [17:0] yaw_a, yaw_b, pitch_a, pitch_b;
   logic signed [16:0] scale_s;
   logic               advance;

   // stage registers
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff;
   logic s7_valid_ff, s8_valid_ff, s9_valid_ff, s10_valid_ff;

   logic signed [40:0] s1_dx_ff, s1_dz_ff, s1_dx_in, s1_dz_in;
   logic signed [43:0] s1_dy_ff, s1_dy_in;

   logic signed [58:0] s2_bx_ff, s2_az_ff, s2_ax_ff, s2_bz_ff;
   logic signed [43:0] s2_dy_ff;

   logic signed [59:0] s3_sum_a, s3_sum_b;
   logic signed [42:0] s3_a_ff, s3_b_ff;
   logic signed [43:0] s3_dy_ff;

   logic signed [61:0] s4_pbdy_ff, s4_pab_ff, s4_pady_ff, s4_pbb_ff;
   logic signed [59:0] s4_sca_ff;

   logic signed [62:0] s5_sum_c, s5_sum_d;
   logic signed [45:0] s5_c_ff, s5_d_ff;
   logic signed [47:0] s5_hx_ff;

   logic signed [62:0]  s6_scc_ff;
   logic signed [47:0]  s6_hx_ff;
   logic signed [45:0]  s6_d_ff;
   logic [DEN_W-1:0]    s6_den_ff, s6_num_ff, s6_den_in;
   logic                s6_knee_ff;

   cpp_div_type          div_in_word;
   cpp_side_type         div_in_side;
   logic                 div_valid;
   logic [DIV_STEPS-1:0] div_quo;
   cpp_side_type         div_side;

   logic signed [46:0] s7_flat_f;
   logic [45:0]        s7_f_ff;
   logic [47:0]        s7_mx_ff;
   logic [50:0]        s7_my_ff;
   logic               s7_sx_ff, s7_sy_ff;
   logic signed [47:0] s7_hx_ff;
   logic signed [50:0] s7_hy_ff;

   logic [50:0]        s8_mx_wide;
   logic [48:0]        s8_xll_ff, s8_xlh_ff, s8_yll_ff, s8_ylh_ff;
   logic [47:0]        s8_xhl_ff, s8_xhh_ff, s8_yhl_ff, s8_yhh_ff;
   logic               s8_sx_ff, s8_sy_ff;
   logic signed [47:0] s8_hx_ff;
   logic signed [50:0] s8_hy_ff;

   logic [96:0]        s9_px_ff, s9_py_ff;
   logic               s9_sx_ff, s9_sy_ff;
   logic signed [47:0] s9_hx_ff;
   logic signed [50:0] s9_hy_ff;

   logic               persp;
   logic signed [50:0] s10_selx_ff, s10_sely_ff;

   // output side
   logic signed [52:0] out_sum_x, out_sum_y;
   rsp_word_type       result;
   logic               load_out, incoming;
   logic               rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   rsp_word_type       rsp_word_ff, skid_word_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff        <= '0;
         camera_y_ff        <= '0;
         camera_z_ff        <= '0;
         yaw_pair_ff        <= '0;
         pitch_pair_ff      <= '0;
         screen_centre_ff   <= '0;
         view_scale_ff      <= '0;
         projection_mode_ff <= MODE_NONE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CAMERA_X:        camera_x_ff        <= csr_wdata[31:0];
            CSR_CAMERA_Y:        camera_y_ff        <= csr_wdata[31:0];
            CSR_CAMERA_Z:        camera_z_ff        <= csr_wdata[31:0];
            CSR_YAW_PAIR:        yaw_pair_ff        <= csr_wdata[35:0];
            CSR_PITCH_PAIR:      pitch_pair_ff      <= csr_wdata[35:0];
            CSR_SCREEN_CENTRE:   screen_centre_ff   <= csr_wdata[23:0];
            CSR_VIEW_SCALE:      view_scale_ff      <= csr_wdata[15:0];
            CSR_PROJECTION_MODE: projection_mode_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign yaw_a   = yaw_pair_ff[35:18];
   assign yaw_b   = yaw_pair_ff[17:0];
   assign pitch_a = pitch_pair_ff[35:18];
   assign pitch_b = pitch_pair_ff[17:0];
   assign scale_s = {1'b0, view_scale_ff};
   assign persp   = projection_mode_ff == MODE_PERSP;

   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   // camera offset
   assign s1_dx_in = 41'($signed(req_word.world_x)) - 41'($signed({camera_x_ff, 8'd0}));
   assign s1_dz_in = 41'($signed(req_word.world_z)) - 41'($signed({camera_z_ff, 8'd0}));
   assign s1_dy_in = 44'($signed({req_word.world_y, 3'd0}))
                   - 44'($signed({camera_y_ff, 11'd0}));

   // rotation sums
   assign s3_sum_a = 60'(s2_bx_ff) - 60'(s2_az_ff);
   assign s3_sum_b = 60'(s2_ax_ff) + 60'(s2_bz_ff);
   assign s5_sum_c = 63'(s4_pbdy_ff) - 63'(s4_pab_ff);
   assign s5_sum_d = 63'(s4_pady_ff) + 63'(s4_pbb_ff);

   assign s6_den_in = s5_d_ff[45:0] + 46'(K_Q8);

   always_comb begin
      div_in_word.den    = s6_den_ff;
      div_in_word.num_lo = s6_num_ff[DIV_STEPS-1:0];
      div_in_word.rem    = {{DIV_STEPS{1'b0}}, s6_num_ff[DEN_W-1:DIV_STEPS]};
      div_in_word.quo    = '0;
      div_in_side.hx     = s6_hx_ff;
      div_in_side.hy     = s6_scc_ff[61:11];
      div_in_side.d      = s6_d_ff;
      div_in_side.knee   = s6_knee_ff;
   end

   cpp_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s6_valid_ff),
      .in_div    (div_in_word),
      .in_side   (div_in_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   assign s7_flat_f  = 47'(K_Q8) - 47'(div_side.d);
   assign s8_mx_wide = {3'd0, s7_mx_ff};

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= div_valid;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= s8_valid_ff;
         s10_valid_ff <= s9_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_dx_ff <= s1_dx_in;
         s1_dz_ff <= s1_dz_in;
         s1_dy_ff <= s1_dy_in;

         // yaw products
         s2_bx_ff <= 59'(yaw_b) * 59'(s1_dx_ff);
         s2_az_ff <= 59'(yaw_a) * 59'(s1_dz_ff);
         s2_ax_ff <= 59'(yaw_a) * 59'(s1_dx_ff);
         s2_bz_ff <= 59'(yaw_b) * 59'(s1_dz_ff);
         s2_dy_ff <= s1_dy_ff;

         s3_a_ff  <= s3_sum_a[58:16];
         s3_b_ff  <= s3_sum_b[58:16];
         s3_dy_ff <= s2_dy_ff;

         // pitch products and x scale
         s4_pbdy_ff <= 62'(pitch_b) * 62'(s3_dy_ff);
         s4_pab_ff  <= 62'(pitch_a) * 62'(s3_b_ff);
         s4_pady_ff <= 62'(pitch_a) * 62'(s3_dy_ff);
         s4_pbb_ff  <= 62'(pitch_b) * 62'(s3_b_ff);
         s4_sca_ff  <= 60'(scale_s) * 60'(s3_a_ff);

         s5_c_ff  <= s5_sum_c[61:16];
         s5_d_ff  <= s5_sum_d[61:16];
         s5_hx_ff <= s4_sca_ff[58:11];

         // y scale and divider operands
         s6_scc_ff  <= 63'(scale_s) * 63'(s5_c_ff);
         s6_hx_ff   <= s5_hx_ff;
         s6_d_ff    <= s5_d_ff;
         s6_den_ff  <= s6_den_in;
         s6_num_ff  <= s6_den_in + 46'(NUM_BIAS);
         s6_knee_ff <= s5_d_ff > 46'(KNEE_Q8);

         // shrink factor and magnitudes
         s7_f_ff  <= div_side.knee ? {{(46 - DIV_STEPS){1'b0}}, div_quo} : s7_flat_f[45:0];
         s7_sx_ff <= div_side.hx[47];
         s7_sy_ff <= div_side.hy[50];
         s7_mx_ff <= div_side.hx[47] ? -div_side.hx : div_side.hx;
         s7_my_ff <= div_side.hy[50] ? -div_side.hy : div_side.hy;
         s7_hx_ff <= div_side.hx;
         s7_hy_ff <= div_side.hy;

         // partial products of magnitude and factor
         s8_xll_ff <= 49'(s8_mx_wide[25:0]) * 49'(s7_f_ff[22:0]);
         s8_xlh_ff <= 49'(s8_mx_wide[25:0]) * 49'(s7_f_ff[45:23]);
         s8_xhl_ff <= 48'(s8_mx_wide[50:26]) * 48'(s7_f_ff[22:0]);
         s8_xhh_ff <= 48'(s8_mx_wide[50:26]) * 48'(s7_f_ff[45:23]);
         s8_yll_ff <= 49'(s7_my_ff[25:0]) * 49'(s7_f_ff[22:0]);
         s8_ylh_ff <= 49'(s7_my_ff[25:0]) * 49'(s7_f_ff[45:23]);
         s8_yhl_ff <= 48'(s7_my_ff[50:26]) * 48'(s7_f_ff[22:0]);
         s8_yhh_ff <= 48'(s7_my_ff[50:26]) * 48'(s7_f_ff[45:23]);
         s8_sx_ff  <= s7_sx_ff;
         s8_sy_ff  <= s7_sy_ff;
         s8_hx_ff  <= s7_hx_ff;
         s8_hy_ff  <= s7_hy_ff;

         s9_px_ff <= split_sum(s8_xll_ff, s8_xlh_ff, s8_xhl_ff, s8_xhh_ff);
         s9_py_ff <= split_sum(s8_yll_ff, s8_ylh_ff, s8_yhl_ff, s8_yhh_ff);
         s9_sx_ff <= s8_sx_ff;
         s9_sy_ff <= s8_sy_ff;
         s9_hx_ff <= s8_hx_ff;
         s9_hy_ff <= s8_hy_ff;

         s10_selx_ff <= persp ? shrink_offset(s9_px_ff, s9_sx_ff) : 51'(s9_hx_ff);
         s10_sely_ff <= persp ? shrink_offset(s9_py_ff, s9_sy_ff) : s9_hy_ff;
      end
   end

   // screen placement and saturation
   assign out_sum_x = 53'({screen_centre_ff[23:12], 8'd0}) + 53'(s10_selx_ff);
   assign out_sum_y = 53'({screen_centre_ff[11:0], 8'd0}) - 53'(s10_sely_ff);

   always_comb begin
      if (projection_mode_ff == MODE_NONE) begin
         result = '0;
      end else begin
         result.screen_x    = sat_out(out_sum_x);
         result.screen_y    = sat_out(out_sum_y);
         result.point_valid = 1'b1;
      end
   end

   // output register with skid
   always_comb begin
      load_out = !rsp_valid_ff || rsp_ready;
      incoming = s10_valid_ff && advance;
      if (load_out) begin
         rsp_valid_in  = skid_valid_ff || incoming;
         skid_valid_in = 1'b0;
      end else begin
         rsp_valid_in  = rsp_valid_ff;
         skid_valid_in = skid_valid_ff || incoming;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_word_ff <= skid_valid_ff ? skid_word_ff : result;
      end
      if (!load_out && incoming) begin
         skid_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== bench/tb_camera_point_projection.sv =====
// ---------------------------------------------------------------------------
// tb_camera_point_projection: self-checking bench for the point projector
// Drives world points through the request channel under a series of
// register settings, predicts each screen word with its own fixed-point
// model or takes it from the directed table, and compares the words that come back, in order.
// A short table of directed points comes first, then random traffic with
// random gaps and output stalls on both sides.
// ---------------------------------------------------------------------------
module tb_camera_point_projection;
   timeunit 1ns;
   timeprecision 1ps;

   import cpp_pkg::*;

   localparam int QUIET_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 100;

   localparam logic [1:0] MODE_FLAT  = 2'd1;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   localparam logic [2:0] SET_RESET      = 3'd0;
   localparam logic [2:0] SET_CENTRE     = 3'd1;
   localparam logic [2:0] SET_WILD       = 3'd2;
   localparam logic [2:0] SET_WILD2      = 3'd3;
   localparam logic [2:0] SET_UNIT_FLAT  = 3'd4;
   localparam logic [2:0] SET_UNIT_PERSP = 3'd5;

   localparam logic [31:0] W_MAX = 32'h7fff_ffff;
   localparam logic [31:0] W_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] cam_x;
      logic [31:0] cam_y;
      logic [31:0] cam_z;
      logic [35:0] yaw;
      logic [35:0] pitch;
      logic [23:0] centre;
      logic [15:0] scale;
      logic [1:0]  mode;
   } setup_t;

   typedef struct packed {
      logic [2:0]   setup;
      req_word_type pt;
      logic         known;
      rsp_word_type want;
   } probe_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_word_type          req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_word_type          rsp_word;
   logic                  csr_we;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   longint      cam_x = 0;
   longint      cam_y = 0;
   longint      cam_z = 0;
   logic [35:0] yaw_reg = '0;
   logic [35:0] pitch_reg = '0;
   logic [23:0] centre_reg = '0;
   logic [15:0] scale_reg = '0;
   logic [1:0]  mode_reg = MODE_NONE;

   rsp_word_type screen_due[$];
   probe_t       probes[$];

   int mismatch_count = 0;
   int words_checked  = 0;
   int points_sent    = 0;
   int setups_loaded  = 0;
   int quiet_cycles   = 0;
   int stall_left     = 0;
   bit tx_idle        = 1'b1;
   bit rx_idle        = 1'b1;
   bit rx_hold_req    = 1'b0;

   camera_point_projection uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic signed [23:0] clamp_screen(input longint v);
      longint q;
      q = v >>> 4;
      if (q > OUT_MAX) begin
         q = OUT_MAX;
      end else if (q < OUT_MIN) begin
         q = OUT_MIN;
      end
      return q[23:0];
   endfunction

   function automatic longint shrink_by_depth(input longint v, input longint f);
      longint unsigned mag;
      longint unsigned fu;
      longint          p;
      fu = f;
      mag = (v < 0) ? -v : v;
      if (mag != 0 && fu > (64'd1 << 62) / mag) begin
         return (v < 0) ? -(longint'(1) << 40) : (longint'(1) << 40);
      end
      p = longint'(mag * fu);
      if (v < 0) begin
         p = -p;
      end
      return p >>> 22;
   endfunction

   function automatic rsp_word_type project_point(input req_word_type p);
      rsp_word_type    r;
      longint          dx, dy, dz, ya, yb, pa, pb, ra, rb, rc, dep, hx, hy, sc;
      longint unsigned den;
      r = '0;
      if (mode_reg == MODE_NONE) begin
         return r;
      end
      dx = longint'(p.world_x) - cam_x * 256;
      dy = longint'(p.world_y) * 8 - cam_y * 2048;
      dz = longint'(p.world_z) - cam_z * 256;
      ya = longint'($signed(yaw_reg[35:18]));
      yb = longint'($signed(yaw_reg[17:0]));
      pa = longint'($signed(pitch_reg[35:18]));
      pb = longint'($signed(pitch_reg[17:0]));
      ra = (yb * dx - ya * dz) >>> 16;
      rb = (ya * dx + yb * dz) >>> 16;
      rc = (pb * dy - pa * rb) >>> 16;
      dep = (pa * dy + pb * rb) >>> 16;
      sc = longint'(scale_reg);
      hx = (sc * ra) >>> 11;
      hy = (sc * rc) >>> 11;
      if (mode_reg == MODE_PERSP) begin
         if (dep > KNEE_Q8) begin
            den = dep + K_Q8;
            dep = K_Q8 - longint'(((64'd1 << 44) + den - 64'd1) / den);
         end
         hx = shrink_by_depth(hx, K_Q8 - dep);
         hy = shrink_by_depth(hy, K_Q8 - dep);
      end
      r.screen_x = clamp_screen(longint'(centre_reg[23:12]) * 256 + hx);
      r.screen_y = clamp_screen(longint'(centre_reg[11:0]) * 256 - hy);
      r.point_valid = 1'b1;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [63:0] spread_value(input int w);
      logic [63:0] all;
      logic [63:0] v;
      all = (64'd1 << w) - 64'd1;
      case ($urandom_range(0, 7))
         0: v = '0;
         1: v = all;
         2: v = 64'd1 << (w - 1);
         3: v = all >> 1;
         default: v = {$urandom, $urandom};
      endcase
      return v & all;
   endfunction

   function automatic longint near_offset();
      int sh;
      case ($urandom_range(0, 3))
         0: sh = 8;
         1: sh = 14;
         2: sh = 20;
         default: sh = 24;
      endcase
      return longint'($urandom_range(0, 2 << sh)) - (longint'(1) << sh);
   endfunction

   function automatic req_word_type fresh_point();
      req_word_type p;
      if ($urandom_range(0, 9) < 8) begin
         p.world_x = 32'(cam_x * 256 + near_offset());
         p.world_y = 32'(cam_y * 256 + (near_offset() >>> 3));
         p.world_z = 32'(cam_z * 256 + near_offset());
      end else begin
         p.world_x = 32'(spread_value(32));
         p.world_y = 32'(spread_value(32));
         p.world_z = 32'(spread_value(32));
      end
      return p;
   endfunction

   function automatic setup_t random_setup();
      setup_t s;
      if ($urandom_range(0, 9) < 7) begin
         s.cam_x = 32'($urandom_range(0, 512)) - 32'd256;
         s.cam_y = 32'($urandom_range(0, 128)) - 32'd64;
         s.cam_z = 32'($urandom_range(0, 512)) - 32'd256;
         s.yaw = {18'($urandom_range(0, 131072) - 65536),
                  18'($urandom_range(0, 131072) - 65536)};
         s.pitch = {18'($urandom_range(0, 131072) - 65536),
                    18'($urandom_range(0, 131072) - 65536)};
         s.centre = 24'($urandom);
         s.scale = 16'($urandom_range(256, 8192));
      end else begin
         s.cam_x = 32'(spread_value(32));
         s.cam_y = 32'(spread_value(32));
         s.cam_z = 32'(spread_value(32));
         s.yaw = {18'(spread_value(18)), 18'(spread_value(18))};
         s.pitch = {18'(spread_value(18)), 18'(spread_value(18))};
         s.centre = 24'(spread_value(24));
         s.scale = 16'(spread_value(16));
      end
      case ($urandom_range(0, 9))
         0: s.mode = MODE_NONE;
         1, 2, 3: s.mode = MODE_FLAT;
         9: s.mode = MODE_SPARE;
         default: s.mode = MODE_PERSP;
      endcase
      return s;
   endfunction

   function automatic setup_t preset_setup(input logic [2:0] idx);
      setup_t s;
      s = '0;
      case (idx)
         SET_CENTRE: begin
            s.centre = 24'hff_ffff;
            s.mode = MODE_FLAT;
         end
         SET_WILD: begin
            s.cam_x = W_MAX;
            s.cam_y = W_MIN;
            s.cam_z = W_MAX;
            s.yaw = {18'h1ffff, 18'h20000};
            s.pitch = {18'h20000, 18'h1ffff};
            s.scale = 16'hffff;
            s.mode = MODE_PERSP;
         end
         SET_WILD2: begin
            s.cam_x = W_MIN;
            s.cam_y = W_MAX;
            s.cam_z = W_MIN;
            s.yaw = {18'h20000, 18'h1ffff};
            s.pitch = {18'h1ffff, 18'h20000};
            s.centre = 24'hfff000;
            s.scale = 16'hffff;
            s.mode = MODE_FLAT;
         end
         SET_UNIT_FLAT, SET_UNIT_PERSP: begin
            s.yaw = {18'd0, 18'd65536};
            s.pitch = {18'd0, 18'd65536};
            s.centre = {12'd100, 12'd200};
            s.scale = 16'd2048;
            s.mode = (idx == SET_UNIT_FLAT) ? MODE_SPARE : MODE_PERSP;
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic add_probe(input logic [2:0] setup, input logic [31:0] x, y, z,
                            input logic known, input logic [23:0] sx, sy, input logic pv);
      probe_t row;
      row.setup = setup;
      row.pt = {x, y, z};
      row.known = known;
      row.want = {sx, sy, pv};
      probes.push_back(row);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_screen(input rsp_word_type got);
      rsp_word_type want;
      if (screen_due.size() == 0) begin
         report_mismatch("word with none expected, screen_x", got.screen_x, 0);
      end else begin
         want = screen_due.pop_front();
         words_checked++;
         if (got.screen_x !== want.screen_x) begin
            report_mismatch("screen_x", got.screen_x, want.screen_x);
         end
         if (got.screen_y !== want.screen_y) begin
            report_mismatch("screen_y", got.screen_y, want.screen_y);
         end
         if (got.point_valid !== want.point_valid) begin
            report_mismatch("point_valid", got.point_valid, want.point_valid);
         end
      end
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_setup(input setup_t s);
      write_csr(CSR_CAMERA_X, {4'($urandom), s.cam_x});
      write_csr(CSR_CAMERA_Y, {4'($urandom), s.cam_y});
      write_csr(CSR_CAMERA_Z, {4'($urandom), s.cam_z});
      write_csr(CSR_YAW_PAIR, s.yaw);
      write_csr(CSR_PITCH_PAIR, s.pitch);
      write_csr(CSR_SCREEN_CENTRE, {12'($urandom), s.centre});
      write_csr(CSR_VIEW_SCALE, {20'($urandom), s.scale});
      write_csr(CSR_PROJECTION_MODE, {32'($urandom), 2'($urandom), s.mode});
      csr_we <= 1'b0;
      cam_x = longint'($signed(s.cam_x));
      cam_y = longint'($signed(s.cam_y));
      cam_z = longint'($signed(s.cam_z));
      yaw_reg = s.yaw;
      pitch_reg = s.pitch;
      centre_reg = s.centre;
      scale_reg = s.scale;
      mode_reg = s.mode;
      setups_loaded++;
   endtask

   task automatic run_point(input req_word_type pt, input logic known,
                            input rsp_word_type want);
      int gap;
      gap = tx_idle ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= pt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      screen_due.push_back(known ? want : project_point(pt));
      points_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (screen_due.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // output side: stalls, one long hold on request, and the word checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         check_screen(rsp_word);
      end
      if (rx_hold_req) begin
         stall_left = HOLD_CYCLES;
         rx_hold_req = 1'b0;
      end else if (stall_left == 0 && rx_idle && $urandom_range(0, 3) == 0) begin
         stall_left = pick_gap();
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int cur_setup;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_CAMERA_X;
      csr_wdata = '0;

      // mode 0 after reset, flat with zero scale, extremes, unit rotation, depth
      add_probe(SET_RESET, 32'd0, 32'd0, 32'd0, 1'b1, 24'd0, 24'd0, 1'b0);
      add_probe(SET_RESET, W_MAX, W_MAX, W_MAX, 1'b1, 24'd0, 24'd0, 1'b0);
      add_probe(SET_RESET, W_MIN, W_MIN, W_MIN, 1'b1, 24'd0, 24'd0, 1'b0);
      add_probe(SET_CENTRE, W_MIN, W_MAX, W_MIN, 1'b1, 24'd65520, 24'd65520, 1'b1);
      add_probe(SET_CENTRE, W_MAX, W_MIN, W_MAX, 1'b1, 24'd65520, 24'd65520, 1'b1);
      add_probe(SET_CENTRE, 32'd0, 32'd0, 32'd0, 1'b1, 24'd65520, 24'd65520, 1'b1);
      add_probe(SET_WILD, W_MAX, W_MAX, W_MAX, 1'b0, '0, '0, 1'b0);
      add_probe(SET_WILD, W_MIN, W_MIN, W_MIN, 1'b0, '0, '0, 1'b0);
      add_probe(SET_WILD, W_MAX, W_MIN, 32'd0, 1'b0, '0, '0, 1'b0);
      add_probe(SET_WILD, 32'd0, 32'd0, 32'd0, 1'b0, '0, '0, 1'b0);
      add_probe(SET_WILD2, W_MIN, W_MAX, W_MIN, 1'b0, '0, '0, 1'b0);
      add_probe(SET_WILD2, W_MAX, W_MIN, W_MAX, 1'b0, '0, '0, 1'b0);
      add_probe(SET_WILD2, 32'd0, 32'd0, 32'd0, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_FLAT, 32'd4096, 32'd32, 32'd0, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_FLAT, -32'sd4096, -32'sd32, 32'd1000, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_FLAT, W_MAX, W_MAX, W_MAX, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_PERSP, 32'd4096, 32'd64, 32'd262144, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_PERSP, 32'd4096, 32'd64, 32'd262145, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_PERSP, 32'd4096, 32'd64, W_MAX, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_PERSP, -32'sd4096, -32'sd64, -32'sd100000, 1'b0, '0, '0, 1'b0);
      add_probe(SET_UNIT_PERSP, W_MIN, 32'd0, W_MIN, 1'b1, 24'h800000, 24'd3200, 1'b1);
      add_probe(SET_UNIT_PERSP, W_MAX, 32'd0, W_MIN, 1'b1, 24'h7fffff, 24'd3200, 1'b1);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      cur_setup = SET_RESET;

      foreach (probes[i]) begin
         if (probes[i].setup != cur_setup) begin
            settle();
            load_setup(preset_setup(probes[i].setup));
            cur_setup = probes[i].setup;
         end
         run_point(probes[i].pt, probes[i].known, probes[i].want);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         load_setup(random_setup());
         tx_idle = (ph != 0) && (ph != 2) && ($urandom_range(0, 3) != 0);
         rx_idle = (ph != 0) && (ph != 2) && ($urandom_range(0, 3) != 0);
         if (ph == 2) begin
            rx_hold_req = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 4 && i == PHASE_ITEMS / 2) begin
               settle();
            end
            run_point(fresh_point(), 1'b0, '0);
         end
      end
      settle();

      $display("covered %0d points under %0d register settings: directed extremes, depth knee,",
               points_sent, setups_loaded);
      $display("overflow guard and random traffic with stalls; %0d words compared",
               words_checked);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
